FILE: rtl/ami_pkg.sv
// shared types, cofactor index table and saturation for the affine inverse
package ami_pkg;

   localparam int WORD_W = 32;
   localparam int EXT_W  = 72;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef word_type [8:0] lin_type;
   typedef word_type [2:0] vec_type;

   // adjugate entry k = m[a] * m[b] - m[c] * m[d], flattened row by row
   localparam int COF_IDX [9][4] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
   };

   localparam logic signed [EXT_W-1:0] SAT_HI = 72'sd2147483647;
   localparam logic signed [EXT_W-1:0] SAT_LO = -72'sd2147483648;

   function automatic word_type sat32(input logic signed [EXT_W-1:0] v);
      word_type r;
      if (v > SAT_HI) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/ami_rnd.sv
// round to nearest, ties away from zero, dropping the fraction bits
module ami_rnd #(
   parameter int IW = 64,
   parameter int FB = 16
) (
   input  logic signed [IW-1:0] p,
   output logic signed [IW-FB:0] r
);

   logic signed [IW:0] ext;
   logic signed [IW:0] sum;

   assign ext = {p[IW-1], p};
   assign sum = ext + (IW+1)'(64'd1 << (FB - 1)) - (IW+1)'(p[IW-1]);
   assign r   = sum[IW:FB];

endmodule

FILE: rtl/ami_cof.sv
// cofactor stages: paired products, then difference, rounding and saturation
module ami_cof #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ami_pkg::lin_type  in_m,
   input  ami_pkg::vec_type  in_t,
   output logic              out_valid,
   output ami_pkg::lin_type  out_m,
   output ami_pkg::lin_type  out_c,
   output ami_pkg::vec_type  out_t
);

   localparam int RW = 66 - FRAC_BITS;

   logic                   v1_ff, v2_ff;
   logic signed [63:0]     pa_ff [9];
   logic signed [63:0]     pb_ff [9];
   ami_pkg::lin_type       m1_ff, m2_ff, c_ff;
   ami_pkg::vec_type       t1_ff, t2_ff;
   logic signed [64:0]     diff [9];
   logic signed [RW-1:0]   rd [9];
   ami_pkg::lin_type       c_in;

   for (genvar k = 0; k < 9; k++) begin : g_cof
      always_ff @(posedge clock) begin
         pa_ff[k] <= $signed(in_m[ami_pkg::COF_IDX[k][0]])
                     * $signed(in_m[ami_pkg::COF_IDX[k][1]]);
         pb_ff[k] <= $signed(in_m[ami_pkg::COF_IDX[k][2]])
                     * $signed(in_m[ami_pkg::COF_IDX[k][3]]);
      end
      assign diff[k] = 65'(pa_ff[k]) - 65'(pb_ff[k]);
      ami_rnd #(.IW(65), .FB(FRAC_BITS)) u_rnd (.p(diff[k]), .r(rd[k]));
      assign c_in[k] = ami_pkg::sat32(ami_pkg::EXT_W'(rd[k]));
   end

   always_ff @(posedge clock) begin
      m1_ff <= in_m;
      t1_ff <= in_t;
      m2_ff <= m1_ff;
      t2_ff <= t1_ff;
      c_ff  <= c_in;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_m     = m2_ff;
   assign out_c     = c_ff;
   assign out_t     = t2_ff;

endmodule

FILE: rtl/ami_det.sv
// determinant stages: first-row products, then rounded sum and saturation
module ami_det #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ami_pkg::lin_type  in_m,
   input  ami_pkg::lin_type  in_c,
   input  ami_pkg::vec_type  in_t,
   output logic              out_valid,
   output ami_pkg::word_type out_det,
   output logic              out_zero,
   output ami_pkg::lin_type  out_c,
   output ami_pkg::vec_type  out_t
);

   localparam int RW = 65 - FRAC_BITS;

   logic                        v1_ff, v2_ff;
   logic signed [63:0]          dp_ff [3];
   ami_pkg::lin_type            c1_ff, c2_ff;
   ami_pkg::vec_type            t1_ff, t2_ff;
   logic signed [RW-1:0]        rd [3];
   logic signed [ami_pkg::EXT_W-1:0] sum;
   ami_pkg::word_type           det_ff, det_in;
   logic                        zero_ff;

   for (genvar k = 0; k < 3; k++) begin : g_dp
      always_ff @(posedge clock) begin
         dp_ff[k] <= $signed(in_m[k]) * $signed(in_c[3*k]);
      end
      ami_rnd #(.IW(64), .FB(FRAC_BITS)) u_rnd (.p(dp_ff[k]), .r(rd[k]));
   end

   assign sum = ami_pkg::EXT_W'(rd[0]) + ami_pkg::EXT_W'(rd[1])
              + ami_pkg::EXT_W'(rd[2]);
   assign det_in = ami_pkg::sat32(sum);

   always_ff @(posedge clock) begin
      c1_ff   <= in_c;
      t1_ff   <= in_t;
      c2_ff   <= c1_ff;
      t2_ff   <= t1_ff;
      det_ff  <= det_in;
      zero_ff <= (det_in == '0);
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_det   = det_ff;
   assign out_zero  = zero_ff;
   assign out_c     = c2_ff;
   assign out_t     = t2_ff;

endmodule

FILE: rtl/ami_recip.sv
// pipelined restoring divider, one quotient bit per stage, for the reciprocal
module ami_recip #(
   parameter int FRAC_BITS = 16,
   parameter int PW        = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ami_pkg::word_type in_det,
   input  logic [PW-1:0]     in_pay,
   output logic              out_valid,
   output ami_pkg::word_type out_inv,
   output logic [PW-1:0]     out_pay
);

   localparam int NW = ((2 * FRAC_BITS > 30) ? 2 * FRAC_BITS : 30) + 2;

   logic              v_ff   [NW+1];
   logic              neg_ff [NW+1];
   logic [31:0]       d_ff   [NW+1];
   logic [31:0]       rem_ff [NW+1];
   logic [NW-1:0]     num_ff [NW+1];
   logic [NW-1:0]     quo_ff [NW+1];
   logic [PW-1:0]     pay_ff [NW+1];
   logic              vo_ff;
   ami_pkg::word_type inv_ff;
   logic [PW-1:0]     payo_ff;
   logic [31:0]       d_in;
   logic [NW-1:0]     num_in;
   logic signed [ami_pkg::EXT_W-1:0] qx;

   assign d_in   = in_det[31] ? (~in_det + 32'd1) : in_det;
   assign num_in = (NW'(1) << (2 * FRAC_BITS)) + NW'(d_in >> 1);

   always_ff @(posedge clock) begin
      neg_ff[0] <= in_det[31];
      d_ff[0]   <= d_in;
      rem_ff[0] <= '0;
      num_ff[0] <= num_in;
      quo_ff[0] <= '0;
      pay_ff[0] <= in_pay;
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   for (genvar k = 0; k < NW; k++) begin : g_div
      logic [32:0] rem_sh;
      logic        ge;
      logic [32:0] rem_sub;
      assign rem_sh  = {rem_ff[k], num_ff[k][NW-1]};
      assign ge      = rem_sh >= {1'b0, d_ff[k]};
      assign rem_sub = rem_sh - {1'b0, d_ff[k]};
      always_ff @(posedge clock) begin
         neg_ff[k+1] <= neg_ff[k];
         d_ff[k+1]   <= d_ff[k];
         rem_ff[k+1] <= ge ? rem_sub[31:0] : rem_sh[31:0];
         num_ff[k+1] <= num_ff[k] << 1;
         quo_ff[k+1] <= {quo_ff[k][NW-2:0], ge};
         pay_ff[k+1] <= pay_ff[k];
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else begin
            v_ff[k+1] <= v_ff[k];
         end
      end
   end

   assign qx = {{(ami_pkg::EXT_W-NW){1'b0}}, quo_ff[NW]};

   always_ff @(posedge clock) begin
      inv_ff  <= ami_pkg::sat32(neg_ff[NW] ? -qx : qx);
      payo_ff <= pay_ff[NW];
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= v_ff[NW];
      end
   end

   assign out_valid = vo_ff;
   assign out_inv   = inv_ff;
   assign out_pay   = payo_ff;

endmodule

FILE: rtl/ami_scale.sv
// scaling stages: inverse linear part, then inverse translation and result register
module ami_scale #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ami_pkg::word_type in_inv,
   input  logic              in_zero,
   input  ami_pkg::lin_type  in_c,
   input  ami_pkg::vec_type  in_t,
   output logic              out_valid,
   output ami_pkg::lin_type  out_o,
   output ami_pkg::vec_type  out_ot
);

   localparam int RW = 65 - FRAC_BITS;
   localparam ami_pkg::word_type ONE = 32'(64'd1 << FRAC_BITS);

   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic                  z1_ff, z2_ff, z3_ff;
   ami_pkg::vec_type      t1_ff, t2_ff;
   logic signed [63:0]    p_ff [9];
   logic signed [63:0]    q_ff [9];
   logic signed [RW-1:0]  pr [9];
   logic signed [RW-1:0]  qr [9];
   ami_pkg::lin_type      o_in, o2_ff, o3_ff, o_ff, o_out_in;
   ami_pkg::vec_type      ot_ff, ot_in;

   for (genvar k = 0; k < 9; k++) begin : g_lin
      always_ff @(posedge clock) begin
         p_ff[k] <= $signed(in_inv) * $signed(in_c[k]);
         q_ff[k] <= $signed(t2_ff[k/3]) * $signed(o2_ff[k]);
      end
      ami_rnd #(.IW(64), .FB(FRAC_BITS)) u_prnd (.p(p_ff[k]), .r(pr[k]));
      ami_rnd #(.IW(64), .FB(FRAC_BITS)) u_qrnd (.p(q_ff[k]), .r(qr[k]));
      assign o_in[k]     = ami_pkg::sat32(ami_pkg::EXT_W'(pr[k]));
      assign o_out_in[k] = z3_ff ? (((k % 4) == 0) ? ONE : '0) : o3_ff[k];
   end

   for (genvar j = 0; j < 3; j++) begin : g_tr
      logic signed [ami_pkg::EXT_W-1:0] s;
      assign s = ami_pkg::EXT_W'(qr[j]) + ami_pkg::EXT_W'(qr[3+j])
               + ami_pkg::EXT_W'(qr[6+j]);
      assign ot_in[j] = z3_ff ? '0 : ami_pkg::sat32(-s);
   end

   always_ff @(posedge clock) begin
      t1_ff <= in_t;
      z1_ff <= in_zero;
      t2_ff <= t1_ff;
      z2_ff <= z1_ff;
      o2_ff <= o_in;
      z3_ff <= z2_ff;
      o3_ff <= o2_ff;
      o_ff  <= o_out_in;
      ot_ff <= ot_in;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_o     = o_ff;
   assign out_ot    = ot_ff;

endmodule

FILE: rtl/affine_matrix_inverse.sv
// top level of the pipelined affine 4x4 inverse
//
//  channel   ports                     transfer when
//  request   req_in_*, start, busy     start high and busy low
//  response  rsp_out_*, rsp_valid      rsp_valid high, one cycle
//
//  a new matrix may enter in every cycle; busy is never raised
//  NW = max(2*FRAC_BITS, 30) + 2 is the number of divider stages
//  the divider, one quotient bit per stage, is by far the longest part of the pipeline
//  reset clears all valid bits at once; there is no clearing pass
//  the receiver cannot stall, so results are never held back
module affine_matrix_inverse #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ami_pkg::word_type  req_in_r1c1,
   input  ami_pkg::word_type  req_in_r1c2,
   input  ami_pkg::word_type  req_in_r1c3,
   input  ami_pkg::word_type  req_in_r2c1,
   input  ami_pkg::word_type  req_in_r2c2,
   input  ami_pkg::word_type  req_in_r2c3,
   input  ami_pkg::word_type  req_in_r3c1,
   input  ami_pkg::word_type  req_in_r3c2,
   input  ami_pkg::word_type  req_in_r3c3,
   input  ami_pkg::word_type  req_in_tx,
   input  ami_pkg::word_type  req_in_ty,
   input  ami_pkg::word_type  req_in_tz,
   output logic               rsp_valid,
   output ami_pkg::word_type  rsp_out_r1c1,
   output ami_pkg::word_type  rsp_out_r1c2,
   output ami_pkg::word_type  rsp_out_r1c3,
   output ami_pkg::word_type  rsp_out_r2c1,
   output ami_pkg::word_type  rsp_out_r2c2,
   output ami_pkg::word_type  rsp_out_r2c3,
   output ami_pkg::word_type  rsp_out_r3c1,
   output ami_pkg::word_type  rsp_out_r3c2,
   output ami_pkg::word_type  rsp_out_r3c3,
   output ami_pkg::word_type  rsp_out_tx,
   output ami_pkg::word_type  rsp_out_ty,
   output ami_pkg::word_type  rsp_out_tz
);

   localparam int NW  = ((2 * FRAC_BITS > 30) ? 2 * FRAC_BITS : 30) + 2;
   localparam int PW  = 12 * ami_pkg::WORD_W + 1;
   localparam int LAT = NW + 10;

   ami_pkg::lin_type  m, cof_m, cof_c, det_c, rc_c, o;
   ami_pkg::vec_type  t, cof_t, det_t, rc_t, ot;
   logic              in_valid, cof_valid, det_valid, inv_valid;
   logic              det_zero, rc_zero;
   ami_pkg::word_type det, inv;
   logic [PW-1:0]     pay_in, pay_out;

   assign busy     = 1'b0;
   assign in_valid = start && !busy;

   assign m = {req_in_r3c3, req_in_r3c2, req_in_r3c1,
               req_in_r2c3, req_in_r2c2, req_in_r2c1,
               req_in_r1c3, req_in_r1c2, req_in_r1c1};
   assign t = {req_in_tz, req_in_ty, req_in_tx};

   ami_cof #(.FRAC_BITS(FRAC_BITS)) u_cof (
      .clock(clock), .reset(reset), .in_valid(in_valid), .in_m(m), .in_t(t),
      .out_valid(cof_valid), .out_m(cof_m), .out_c(cof_c), .out_t(cof_t)
   );

   ami_det #(.FRAC_BITS(FRAC_BITS)) u_det (
      .clock(clock), .reset(reset), .in_valid(cof_valid), .in_m(cof_m),
      .in_c(cof_c), .in_t(cof_t), .out_valid(det_valid), .out_det(det),
      .out_zero(det_zero), .out_c(det_c), .out_t(det_t)
   );

   assign pay_in = {det_zero, det_c, det_t};

   ami_recip #(.FRAC_BITS(FRAC_BITS), .PW(PW)) u_recip (
      .clock(clock), .reset(reset), .in_valid(det_valid), .in_det(det),
      .in_pay(pay_in), .out_valid(inv_valid), .out_inv(inv), .out_pay(pay_out)
   );

   assign {rc_zero, rc_c, rc_t} = pay_out;

   ami_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
      .clock(clock), .reset(reset), .in_valid(inv_valid), .in_inv(inv),
      .in_zero(rc_zero), .in_c(rc_c), .in_t(rc_t), .out_valid(rsp_valid),
      .out_o(o), .out_ot(ot)
   );

   assign rsp_out_r1c1 = o[0];
   assign rsp_out_r1c2 = o[1];
   assign rsp_out_r1c3 = o[2];
   assign rsp_out_r2c1 = o[3];
   assign rsp_out_r2c2 = o[4];
   assign rsp_out_r2c3 = o[5];
   assign rsp_out_r3c1 = o[6];
   assign rsp_out_r3c2 = o[7];
   assign rsp_out_r3c3 = o[8];
   assign rsp_out_tx   = ot[0];
   assign rsp_out_ty   = ot[1];
   assign rsp_out_tz   = ot[2];

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(in_valid, LAT))
      else $error("response without matching request");

   a_inv_from_det: assert property (@(posedge clock) disable iff (reset)
      inv_valid |-> $past(det_valid, NW + 2))
      else $error("reciprocal without matching determinant");

   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

endmodule
